/* design/dem_pkg.sv */
// ----------------------------------------------------------------------------
// dem_pkg: shared types and constants for the disparity error metrics block
// Widths, payload structs and the saturating counter step.
// ----------------------------------------------------------------------------
`default_nettype none

package dem_pkg;

	localparam int DISP_W           = 16;
	localparam int SQ_W             = 2 * DISP_W;
	localparam int SUM_W            = 56;
	localparam int ROOT_W           = SUM_W / 2;
	localparam int CNT_W            = 23;
	localparam int MAX_FRAME_PIXELS = 4194304;
	localparam int PCT_SCALE        = 10000;
	localparam int PCT_W            = 14;
	localparam int PROD_W           = CNT_W + PCT_W;
	localparam int RMS_W            = 16;
	localparam int MASK_W           = 8;
	localparam int DIV_ITER_W       = $clog2(SUM_W);
	localparam int SQRT_ITER_W      = $clog2(ROOT_W);

	localparam logic [MASK_W-1:0] MASK_SKIP  = 8'hFF;
	localparam logic [DISP_W-1:0] THR_RESET  = 16'd16;

	typedef struct packed {
		logic [DISP_W-1:0] measured_disparity;
		logic [DISP_W-1:0] true_disparity;
		logic [MASK_W-1:0] mask_value;
		logic              last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [RMS_W-1:0] rms_error;
		logic [PCT_W-1:0] bad_percent_hundredths;
		logic [CNT_W-1:0] bad_pixel_count;
		logic [CNT_W-1:0] evaluated_pixel_count;
		logic             no_evaluated_pixels;
		logic             sum_saturated;
	} metrics_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             saturated;
		logic [CNT_W-1:0] bad;
		logic [CNT_W-1:0] evaluated;
		logic [CNT_W-1:0] pixels;
		logic             busy;
	} accum_status_t;

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
		return (c < CNT_W'(MAX_FRAME_PIXELS)) ? c + CNT_W'(1) : c;
	endfunction

endpackage

`default_nettype wire

/* design/dem_accum.sv */
// ----------------------------------------------------------------------------
// dem_accum: per-pixel accumulation pipeline
// Absolute error, square and saturating sum, plus the frame counters.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_accum (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire dem_pkg::pixel_t         pixel,
	input  wire logic [dem_pkg::DISP_W-1:0] threshold,
	input  wire logic                    clear,
	output dem_pkg::accum_status_t       status
);
	import dem_pkg::*;

	logic              valid_s1;
	logic              keep_s1;
	logic [DISP_W-1:0] err_s1;
	logic              valid_s2;
	logic [SQ_W-1:0]   sq_s2;

	logic [SUM_W-1:0]  sum_q;
	logic              sat_q;
	logic [CNT_W-1:0]  bad_q;
	logic [CNT_W-1:0]  eval_q;
	logic [CNT_W-1:0]  pix_q;

	logic [DISP_W-1:0] err_in;
	logic [SUM_W:0]    sum_ext;

	assign err_in = (pixel.measured_disparity >= pixel.true_disparity)
		? pixel.measured_disparity - pixel.true_disparity
		: pixel.true_disparity - pixel.measured_disparity;

	// carry out of the add means the sum passed its ceiling
	assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_q    <= '0;
			sat_q    <= 1'b0;
			bad_q    <= '0;
			eval_q   <= '0;
			pix_q    <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1 && keep_s1;
			if (clear) begin
				sum_q  <= '0;
				sat_q  <= 1'b0;
				bad_q  <= '0;
				eval_q <= '0;
				pix_q  <= '0;
			end else begin
				if (accept) begin
					pix_q <= count_up(pix_q);
				end
				if (valid_s1 && keep_s1) begin
					eval_q <= count_up(eval_q);
					if (err_s1 > threshold) begin
						bad_q <= count_up(bad_q);
					end
				end
				if (valid_s2) begin
					if (sum_ext[SUM_W]) begin
						sum_q <= '1;
						sat_q <= 1'b1;
					end else begin
						sum_q <= sum_ext[SUM_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		err_s1  <= err_in;
		keep_s1 <= (pixel.mask_value != MASK_SKIP);
		sq_s2   <= err_s1 * err_s1;
	end

	assign status.sum       = sum_q;
	assign status.saturated = sat_q;
	assign status.bad       = bad_q;
	assign status.evaluated = eval_q;
	assign status.pixels    = pix_q;
	assign status.busy      = valid_s1 || valid_s2;

endmodule

`default_nettype wire

/* design/dem_divider.sv */
// ----------------------------------------------------------------------------
// dem_divider: bit-serial restoring divider
// One quotient bit per cycle; dividend shifts out as quotient shifts in.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [dem_pkg::SUM_W-1:0] dividend,
	input  wire logic [dem_pkg::CNT_W-1:0] divisor,
	output logic                           done,
	output logic [dem_pkg::SUM_W-1:0]      quotient
);
	import dem_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_ITER_W-1:0] iter_q;
	logic [SUM_W-1:0]      quo_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      dvs_q;

	logic [CNT_W:0]        trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			// pulse done after the last quotient bit
			done_q <= busy_q && !start && (iter_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= DIV_ITER_W'(SUM_W - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - DIV_ITER_W'(1);
				if (iter_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* design/dem_sqrt.sv */
// ----------------------------------------------------------------------------
// dem_sqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [dem_pkg::SUM_W-1:0]  radicand,
	output logic                            done,
	output logic [dem_pkg::ROOT_W-1:0]      root
);
	import dem_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [SQRT_ITER_W-1:0] iter_q;
	logic [SUM_W-1:0]       val_q;
	logic [ROOT_W+1:0]      rem_q;
	logic [ROOT_W-1:0]      root_q;

	logic [ROOT_W+1:0]      shifted;
	logic [ROOT_W+1:0]      trial;
	logic                   fits;

	assign shifted = {rem_q[ROOT_W-1:0], val_q[SUM_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign fits    = (shifted >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			// pulse done after the last root bit
			done_q <= busy_q && !start && (iter_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= SQRT_ITER_W'(ROOT_W - 1);
			end else if (busy_q) begin
				iter_q <= iter_q - SQRT_ITER_W'(1);
				if (iter_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[SUM_W-3:0], 2'b00};
			rem_q  <= fits ? shifted - trial : shifted;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

/* design/disparity_error_metrics.sv */
// ----------------------------------------------------------------------------
// disparity_error_metrics: stereo disparity RMS error and bad-pixel rate
// Frame statistics over a pixel stream, one result transaction per frame.
// ----------------------------------------------------------------------------
// Within a frame the block takes one pixel transaction per cycle: a short
// pipeline forms |measured - true|, squares it and adds it into a 56-bit
// saturating sum, while the bad, evaluated and total pixel counters advance
// (each saturating at MAX_FRAME_PIXELS). Pixels with mask 255 only bump the
// total count. After the pixel transaction that carries last_pixel, in_ready
// stays low while the frame is closed out: the pipeline drains, the
// bit-serial divider divides the sum by the total pixel count, the
// two-bits-per-cycle square root takes its root, the bad * 10000 product
// is formed and divided by the evaluated count (skipped when every pixel
// was masked), and then the result register is loaded. Both divides use
// the one shared divider, and close-out takes longer while the previous
// result is still unread. The result then waits in its own register, so
// the next frame streams in while out_valid is pending. The threshold
// register resets to 16 (1.0 in Q12.4); write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_error_metrics (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire dem_pkg::pixel_t             in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output dem_pkg::metrics_t                out_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [dem_pkg::DISP_W-1:0]  cfg_data
);
	import dem_pkg::*;

	typedef enum logic [2:0] {
		S_ACCUM,
		S_DRAIN,
		S_DIV_RMS,
		S_SQRT,
		S_PCT_MUL,
		S_PCT_START,
		S_PCT_DIV,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [DISP_W-1:0] thr_q;
	logic [RMS_W-1:0]  rms_q;
	logic [PCT_W-1:0]  pct_q;
	logic [PROD_W-1:0] prod_q;
	logic              out_valid_q;
	metrics_t          out_data_q;

	accum_status_t     acc;
	logic              accept;
	logic              clear;
	logic              slot_free;

	logic              div_start;
	logic [SUM_W-1:0]  div_dividend;
	logic [CNT_W-1:0]  div_divisor;
	logic              div_done;
	logic [SUM_W-1:0]  div_quotient;

	logic              sqrt_start;
	logic              sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	assign in_ready  = (state_q == S_ACCUM);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	// drop the frame totals as the result is loaded
	assign clear     = (state_q == S_EMIT) && slot_free;

	// one divider serves both the mean square and the percentage
	assign div_start    = ((state_q == S_DRAIN) && !acc.busy)
		|| ((state_q == S_PCT_START) && (acc.evaluated != '0));
	assign div_dividend = (state_q == S_DRAIN) ? acc.sum : SUM_W'(prod_q);
	assign div_divisor  = (state_q == S_DRAIN) ? acc.pixels : acc.evaluated;

	assign sqrt_start = (state_q == S_DIV_RMS) && div_done;

	dem_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel     (in_data),
		.threshold (thr_q),
		.clear     (clear),
		.status    (acc)
	);

	dem_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	dem_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quotient),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// frame close-out sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			// a result taken while the next one loads stays valid
			if (out_valid_q && out_ready && !clear) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_ACCUM: begin
					if (accept && in_data.last_pixel) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!acc.busy) begin
						state_q <= S_DIV_RMS;
					end
				end
				S_DIV_RMS: begin
					if (div_done) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						rms_q   <= sqrt_root[RMS_W-1:0];
						state_q <= S_PCT_MUL;
					end
				end
				S_PCT_MUL: begin
					prod_q  <= PROD_W'(acc.bad) * PROD_W'(PCT_SCALE);
					state_q <= S_PCT_START;
				end
				S_PCT_START: begin
					if (acc.evaluated != '0) begin
						state_q <= S_PCT_DIV;
					end else begin
						pct_q   <= '0;
						state_q <= S_EMIT;
					end
				end
				S_PCT_DIV: begin
					if (div_done) begin
						pct_q   <= div_quotient[PCT_W-1:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q                           <= 1'b1;
						out_data_q.rms_error                  <= rms_q;
						out_data_q.bad_percent_hundredths     <= pct_q;
						out_data_q.bad_pixel_count            <= acc.bad;
						out_data_q.evaluated_pixel_count      <= acc.evaluated;
						out_data_q.no_evaluated_pixels        <= (acc.evaluated == '0);
						out_data_q.sum_saturated              <= acc.saturated;
						state_q                               <= S_ACCUM;
					end
				end
				default: begin
					state_q <= S_ACCUM;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// bad pixels are a subset of evaluated pixels
	a_bad_le_eval: assert property (@(posedge clk) disable iff (!arst_n)
		acc.bad <= acc.evaluated)
		else $error("bad count exceeds evaluated count");

	// evaluated pixels never outnumber all pixels
	a_eval_le_pix: assert property (@(posedge clk) disable iff (!arst_n)
		acc.evaluated <= acc.pixels)
		else $error("evaluated count exceeds pixel count");

	// the divider only starts once the pipeline has drained
	a_start_drained: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !acc.busy)
		else $error("division started with pixels in flight");

	// loading a result leaves the frame totals cleared
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (acc.pixels == '0) && (acc.sum == '0) && out_valid_q)
		else $error("frame state not cleared after result load");

endmodule

`default_nettype wire
